// ----- sv/time_message_to_calendar_assert.svh -----
// ----------------------------------------------------------------------------
// Time message to calendar: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef TIME_MESSAGE_TO_CALENDAR_ASSERT_SVH
`define TIME_MESSAGE_TO_CALENDAR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TMC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/tmcal_pkg.sv -----
// ----------------------------------------------------------------------------
// Time message to calendar: shared package
// Descrambling word, epoch offset, reciprocal constants for the division
// stages, status codes and the flag bundle carried down the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tmcal_pkg;

  // Message descrambling and time base.
  localparam logic [39:0] SCRAMBLE_WORD   = 40'h0A47554D2B;
  localparam logic [31:0] EPOCH_2000_UNIX = 32'd946684800;

  // Unix seconds divided by 128 leaves a divide by 675 for the day count.
  localparam logic [25:0] RECIP_675 = 26'd50903316;
  localparam int          SH_675    = 35;
  localparam logic [24:0] DIV_675   = 25'd675;
  localparam logic [10:0] DIV_675_S = 11'd675;

  // Divide by 15 (used for /60 after dropping two bits).
  localparam logic [15:0] RECIP_15 = 16'd34953;
  localparam int          SH_15    = 19;

  // Divide by 7 for the weekday.
  localparam logic [16:0] RECIP_7 = 17'd74899;
  localparam int          SH_7    = 19;

  // Divide by 365, short operand (doe / 1460) and long operand (yoe).
  localparam logic [15:0] RECIP_365_S = 16'd45965;
  localparam int          SH_365_S    = 24;
  localparam logic [17:0] RECIP_365_L = 18'd183860;
  localparam int          SH_365_L    = 26;

  // Divide by 153 for the March-based month index.
  localparam logic [12:0] RECIP_153 = 13'd6854;
  localparam int          SH_153    = 20;

  // Era split: day counts below this lie in era 4, the rest in era 5.
  localparam logic [15:0] ERA5_FIRST_DAY  = 16'd11017;
  localparam logic [17:0] ERA4_DOE_OFFSET = 18'd135080;

  // Century boundaries inside a 400-year era, in days.
  localparam logic [17:0] DOE_CENT1 = 18'd36524;
  localparam logic [17:0] DOE_CENT2 = 18'd73048;
  localparam logic [17:0] DOE_CENT3 = 18'd109572;
  localparam logic [17:0] DOE_LAST  = 18'd146096;

  // Time-zone offsets in hours.
  localparam logic [1:0] TZ_UTC  = 2'd0;
  localparam logic [1:0] TZ_PLUS1 = 2'd1;
  localparam logic [1:0] TZ_PLUS2 = 2'd2;
  localparam logic [1:0] TZ_PLUS3 = 2'd3;

  // Leap-second status codes.
  localparam logic [1:0] LEAP_NONE   = 2'd0;
  localparam logic [1:0] LEAP_INSERT = 2'd1;
  localparam logic [1:0] LEAP_REMOVE = 2'd2;

  // Status flags decoded from the low seven message bits.
  typedef struct packed {
    logic [1:0] tz_offset_hours;
    logic       summer_time;
    logic       zone_change_announced;
    logic [1:0] leap_second_status;
    logic [1:0] transmitter_state;
  } flags_t;

  // Time of day fields carried alongside the date path.
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] weekday;
  } tod_t;

  // First day of each March-based month within the year.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

// ----- sv/time_message_to_calendar.sv -----
// ----------------------------------------------------------------------------
// Time message to calendar converter
// One beat per cycle while out_stall is low; out_stall holds the pipeline.
// Twelve register stages, each with its own valid bit; bubbles are squeezed.
// Synchronous active-high reset clears every valid bit; data is not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "time_message_to_calendar_assert.svh"

module time_message_to_calendar (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [39:0]         scrambled_payload,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [6:0]          year_of_century,
  output logic [3:0]          month,
  output logic [4:0]          day,
  output logic [4:0]          hour,
  output logic [5:0]          minute,
  output logic [5:0]          second,
  output logic [2:0]          weekday,
  output logic [1:0]          tz_offset_hours,
  output logic                summer_time,
  output logic                zone_change_announced,
  output logic [1:0]          leap_second_status,
  output logic [1:0]          transmitter_state
);
  import tmcal_pkg::*;

  // Per-stage valid bits and load enables.
  logic         v  [1:12];
  logic         en [1:12];
  flags_t       flg [1:12];
  tod_t         tod [7:12];

  // A stage loads when it is empty or when the stage after it loads.
  always_comb begin
    en[12] = !v[12] || !out_stall;
    for (int k = 11; k >= 1; k--) begin
      en[k] = !v[k] || en[k + 1];
    end
  end

  assign in_stall  = !en[1];
  assign out_valid = v[12];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= 12; k++) begin
        v[k] <= 1'b0;
      end
    end else begin
      if (en[1]) begin
        v[1] <= in_valid;
      end
      for (int k = 2; k <= 12; k++) begin
        if (en[k]) begin
          v[k] <= v[k - 1];
        end
      end
    end
  end

  // Stage 1: descramble, decode flags, form Unix seconds.
  logic [39:0] plain;
  logic [29:0] units;
  flags_t      flags_dec;
  logic [31:0] s1_unix;

  assign plain = scrambled_payload ^ SCRAMBLE_WORD;
  assign units = plain[36:7];

  always_comb begin
    case (plain[6:5])
      2'd1:    flags_dec.tz_offset_hours = TZ_PLUS2;
      2'd2:    flags_dec.tz_offset_hours = TZ_PLUS1;
      2'd3:    flags_dec.tz_offset_hours = TZ_PLUS3;
      default: flags_dec.tz_offset_hours = TZ_UTC;
    endcase
    flags_dec.summer_time           = (flags_dec.tz_offset_hours == TZ_PLUS2);
    flags_dec.zone_change_announced = plain[2];
    if (!plain[4]) begin
      flags_dec.leap_second_status = LEAP_NONE;
    end else if (plain[3]) begin
      flags_dec.leap_second_status = LEAP_INSERT;
    end else begin
      flags_dec.leap_second_status = LEAP_REMOVE;
    end
    flags_dec.transmitter_state = plain[1:0];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_unix <= 32'({units, 1'b0}) + 32'(units) + EPOCH_2000_UNIX;
    end
  end

  // Flag bundle enters at stage 1 and rides along with each beat.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      flg[1] <= flags_dec;
    end
    for (int k = 2; k <= 12; k++) begin
      if (en[k]) begin
        flg[k] <= flg[k - 1];
      end
    end
  end

  // Stage 2: estimate the day count from seconds / 128 times 1/675.
  logic [50:0] prod_675;
  logic [31:0] s2_unix;
  logic [15:0] s2_q0;

  assign prod_675 = 51'(s1_unix[31:7]) * 51'(RECIP_675);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_unix <= s1_unix;
      s2_q0   <= prod_675[SH_675 +: 16];
    end
  end

  // Stage 3: remainder of the estimate, below twice the divisor.
  logic [24:0] rem_full;
  logic [6:0]  s3_low7;
  logic [15:0] s3_q0;
  logic [10:0] s3_r0;

  assign rem_full = s2_unix[31:7] - 25'(s2_q0) * DIV_675;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_low7 <= s2_unix[6:0];
      s3_q0   <= s2_q0;
      s3_r0   <= rem_full[10:0];
    end
  end

  // Stage 4: correct the estimate; split into day count and second of day.
  logic        rem_over;
  logic [10:0] rem_fix;
  logic [15:0] s4_days;
  logic [16:0] s4_sod;

  assign rem_over = (s3_r0 >= DIV_675_S);
  assign rem_fix  = rem_over ? (s3_r0 - DIV_675_S) : s3_r0;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_days <= s3_q0 + 16'(rem_over);
      s4_sod  <= {rem_fix[9:0], s3_low7};
    end
  end

  // Stage 5: day of era, minutes of day, weekday quotient.
  logic [30:0] prod_min;
  logic [16:0] x7;
  logic [33:0] prod_wd;
  logic [17:0] doe_next;
  logic [17:0] s5_doe;
  logic [16:0] s5_sod;
  logic [10:0] s5_mins;
  logic [16:0] s5_x7;
  logic [12:0] s5_q7;

  assign prod_min = 31'(s4_sod[16:2]) * 31'(RECIP_15);
  assign x7       = 17'(s4_days) + 17'd3;
  assign prod_wd  = 34'(x7) * 34'(RECIP_7);
  assign doe_next = (s4_days >= ERA5_FIRST_DAY) ? 18'(s4_days - ERA5_FIRST_DAY)
                                                : 18'(s4_days) + ERA4_DOE_OFFSET;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_doe  <= doe_next;
      s5_sod  <= s4_sod;
      s5_mins <= prod_min[SH_15 +: 11];
      s5_x7   <= x7;
      s5_q7   <= prod_wd[SH_7 +: 13];
    end
  end

  // Stage 6: leap corrections of the era, seconds, hours, weekday.
  logic [24:0] prod_hr;
  logic [31:0] prod_1460;
  logic [16:0] sec_full;
  logic [16:0] wd_full;
  logic [17:0] s6_doe;
  logic [6:0]  s6_d1460;
  logic [2:0]  s6_cent;
  logic        s6_last;
  logic [10:0] s6_mins;
  logic [4:0]  s6_hour;
  logic [5:0]  s6_sec;
  logic [2:0]  s6_wd;

  assign prod_hr   = 25'(s5_mins[10:2]) * 25'(RECIP_15);
  assign prod_1460 = 32'(s5_doe[17:2]) * 32'(RECIP_365_S);
  assign sec_full  = s5_sod - 17'(s5_mins) * 17'd60;
  assign wd_full   = s5_x7 - 17'(s5_q7) * 17'd7;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_doe   <= s5_doe;
      s6_d1460 <= prod_1460[SH_365_S +: 7];
      s6_cent  <= 3'(s5_doe >= DOE_CENT1) + 3'(s5_doe >= DOE_CENT2)
                + 3'(s5_doe >= DOE_CENT3) + 3'(s5_doe >= DOE_LAST);
      s6_last  <= (s5_doe == DOE_LAST);
      s6_mins  <= s5_mins;
      s6_hour  <= prod_hr[SH_15 +: 5];
      s6_sec   <= sec_full[5:0];
      s6_wd    <= wd_full[2:0] + 3'd1;
    end
  end

  // Stage 7: leap-adjusted day of era; minute of hour.
  logic [10:0] min_full;
  logic [17:0] s7_doe;
  logic [17:0] s7_t;

  assign min_full = s6_mins - 11'(s6_hour) * 11'd60;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_doe <= s6_doe;
      s7_t   <= s6_doe - 18'(s6_d1460) + 18'(s6_cent) - 18'(s6_last);
    end
  end

  // Time of day enters at stage 7 and rides along with the date path.
  always_ff @(posedge clk) begin
    if (en[7]) begin
      tod[7].hour    <= s6_hour;
      tod[7].minute  <= min_full[5:0];
      tod[7].second  <= s6_sec;
      tod[7].weekday <= s6_wd;
    end
    for (int k = 8; k <= 12; k++) begin
      if (en[k]) begin
        tod[k] <= tod[k - 1];
      end
    end
  end

  // Stage 8: year of era.
  logic [35:0] prod_yoe;
  logic [17:0] s8_doe;
  logic [8:0]  s8_yoe;

  assign prod_yoe = 36'(s7_t) * 36'(RECIP_365_L);

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_doe <= s7_doe;
      s8_yoe <= prod_yoe[SH_365_L +: 9];
    end
  end

  // Stage 9: day of March-based year.
  logic [1:0]  yoe_cent;
  logic [17:0] year_days;
  logic [17:0] doy_full;
  logic [8:0]  s9_yoe;
  logic [8:0]  s9_doy;

  assign yoe_cent  = 2'(s8_yoe >= 9'd100) + 2'(s8_yoe >= 9'd200) + 2'(s8_yoe >= 9'd300);
  assign year_days = 18'(s8_yoe) * 18'd365 + 18'(s8_yoe[8:2]) - 18'(yoe_cent);
  assign doy_full  = s8_doe - year_days;

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s9_yoe <= s8_yoe;
      s9_doy <= doy_full[8:0];
    end
  end

  // Stage 10: March-based month index.
  logic [10:0] mp_num;
  logic [23:0] prod_mp;
  logic [8:0]  s10_yoe;
  logic [8:0]  s10_doy;
  logic [3:0]  s10_mp;

  assign mp_num  = 11'(s9_doy) * 11'd5 + 11'd2;
  assign prod_mp = 24'(mp_num) * 24'(RECIP_153);

  always_ff @(posedge clk) begin
    if (en[10]) begin
      s10_yoe <= s9_yoe;
      s10_doy <= s9_doy;
      s10_mp  <= prod_mp[SH_153 +: 4];
    end
  end

  // Stage 11: day, month, and year within the era with January roll.
  logic       jan_feb;
  logic [8:0] dom_full;
  logic [3:0] s11_month;
  logic [4:0] s11_day;
  logic [8:0] s11_yc;

  assign jan_feb  = (s10_mp >= 4'd10);
  assign dom_full = s10_doy - month_start(s10_mp) + 9'd1;

  always_ff @(posedge clk) begin
    if (en[11]) begin
      s11_month <= jan_feb ? (s10_mp - 4'd9) : (s10_mp + 4'd3);
      s11_day   <= dom_full[4:0];
      s11_yc    <= s10_yoe + 9'(jan_feb);
    end
  end

  // Stage 12: year modulo 100 into the output register.
  logic [8:0] yc_mod;

  always_comb begin
    if (s11_yc >= 9'd400) begin
      yc_mod = s11_yc - 9'd400;
    end else if (s11_yc >= 9'd300) begin
      yc_mod = s11_yc - 9'd300;
    end else if (s11_yc >= 9'd200) begin
      yc_mod = s11_yc - 9'd200;
    end else if (s11_yc >= 9'd100) begin
      yc_mod = s11_yc - 9'd100;
    end else begin
      yc_mod = s11_yc;
    end
  end

  always_ff @(posedge clk) begin
    if (en[12]) begin
      year_of_century <= yc_mod[6:0];
      month           <= s11_month;
      day             <= s11_day;
    end
  end

  // Output fields from the last stage.
  assign hour                  = tod[12].hour;
  assign minute                = tod[12].minute;
  assign second                = tod[12].second;
  assign weekday               = tod[12].weekday;
  assign tz_offset_hours       = flg[12].tz_offset_hours;
  assign summer_time           = flg[12].summer_time;
  assign zone_change_announced = flg[12].zone_change_announced;
  assign leap_second_status    = flg[12].leap_second_status;
  assign transmitter_state     = flg[12].transmitter_state;

  // Checks on the pipeline control and the converted fields.
  `TMC_ASSERT_IMPLY(a_stall_full, in_stall, v[1] && v[6] && v[11] && v[12], "input stalled with a bubble in the pipeline")
  `TMC_ASSERT_IMPLY(a_date_range, out_valid, month >= 4'd1 && month <= 4'd12 && day >= 5'd1 && day <= 5'd31 && year_of_century <= 7'd99, "date field out of range")
  `TMC_ASSERT_IMPLY(a_time_range, out_valid, hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59 && weekday >= 3'd1, "time field out of range")
  `TMC_ASSERT_NEXT(a_out_fill, in_valid && !in_stall && !v[12], v[1], "accepted beat did not enter the pipeline")

endmodule
